// ----- rtl/core/lgi_pkg.sv -----
// Shared types and constants for the Lagrange interpolator pipeline.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lgi_pkg;

  // Default value width (signed fixed point, binary point is transparent)
  localparam int unsigned DATA_WIDTH = 32;

  // Sample points per item and factors per Lagrange term
  localparam int unsigned NPTS = 4;
  localparam int unsigned NFAC = NPTS - 1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_COUNT  = 2'd1,
    ST_COINCIDENT = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic    vld;
    status_t status;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/lgi_front.sv -----
// Front stage: differences, magnitudes, signs and input checks per item.
// Depends on lgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgi_front #(
  parameter int unsigned DW = lgi_pkg::DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DW-1:0]        target_x,
  input  logic [DW-1:0]        x_i     [lgi_pkg::NPTS],
  input  logic [DW-1:0]        y_i     [lgi_pkg::NPTS],
  input  logic [2:0]           point_count,
  output logic [DW-1:0]        ay_o    [lgi_pkg::NPTS],
  output logic [DW-1:0]        nf_o    [lgi_pkg::NPTS][lgi_pkg::NFAC],
  output logic [DW-1:0]        df_o    [lgi_pkg::NPTS][lgi_pkg::NFAC],
  output logic [lgi_pkg::NPTS-1:0] neg_o,
  output lgi_pkg::ctrl_t       ctrl_o
);

  localparam logic [2:0] CNT_MIN = 3'd2;
  localparam logic [2:0] CNT_MAX = 3'd4;

  logic [DW:0]   dt_s [lgi_pkg::NPTS];
  logic [DW-1:0] dt_m [lgi_pkg::NPTS];
  logic [DW:0]   dx_s [lgi_pkg::NPTS][lgi_pkg::NPTS];
  logic [DW-1:0] dx_m [lgi_pkg::NPTS][lgi_pkg::NPTS];
  logic [DW-1:0] ay   [lgi_pkg::NPTS];
  logic [lgi_pkg::NPTS-1:0] sy;
  logic bad_cnt, coinc, err;

  logic [DW-1:0] ay_nxt [lgi_pkg::NPTS];
  logic [DW-1:0] nf_nxt [lgi_pkg::NPTS][lgi_pkg::NFAC];
  logic [DW-1:0] df_nxt [lgi_pkg::NPTS][lgi_pkg::NFAC];
  logic [lgi_pkg::NPTS-1:0] neg_nxt;
  lgi_pkg::ctrl_t ctrl_nxt;

  logic [DW-1:0] ay_r [lgi_pkg::NPTS];
  logic [DW-1:0] nf_r [lgi_pkg::NPTS][lgi_pkg::NFAC];
  logic [DW-1:0] df_r [lgi_pkg::NPTS][lgi_pkg::NFAC];
  logic [lgi_pkg::NPTS-1:0] neg_r;
  lgi_pkg::ctrl_t ctrl_r;

  // Form signed differences and their magnitudes
  always_comb begin
    for (int j = 0; j < lgi_pkg::NPTS; j++) begin
      dt_s[j] = {target_x[DW-1], target_x} - {x_i[j][DW-1], x_i[j]};
      dt_m[j] = dt_s[j][DW] ? DW'(~dt_s[j] + 1'b1) : dt_s[j][DW-1:0];
      ay[j]   = y_i[j][DW-1] ? (~y_i[j] + 1'b1) : y_i[j];
      sy[j]   = y_i[j][DW-1];
      for (int i = 0; i < lgi_pkg::NPTS; i++) begin
        dx_s[i][j] = {x_i[i][DW-1], x_i[i]} - {x_i[j][DW-1], x_i[j]};
        dx_m[i][j] = dx_s[i][j][DW] ? DW'(~dx_s[i][j] + 1'b1) : dx_s[i][j][DW-1:0];
      end
    end
  end

  // Check the point count and look for repeated abscissae among used points
  always_comb begin
    bad_cnt = (point_count < CNT_MIN) || (point_count > CNT_MAX);
    coinc   = 1'b0;
    for (int i = 0; i < lgi_pkg::NPTS; i++) begin
      for (int j = i + 1; j < lgi_pkg::NPTS; j++) begin
        if ((3'(j) < point_count) && (x_i[i] == x_i[j])) begin
          coinc = 1'b1;
        end
      end
    end
    err = bad_cnt || coinc;
  end

  // Pick the three factors of each term; unused slots become one
  always_comb begin
    logic       used_t;
    logic       used_f;
    logic [1:0] jj;
    used_t = 1'b0;
    used_f = 1'b0;
    jj     = '0;
    for (int i = 0; i < lgi_pkg::NPTS; i++) begin
      used_t     = !err && (3'(i) < point_count);
      ay_nxt[i]  = used_t ? ay[i] : '0;
      neg_nxt[i] = sy[i];
      for (int k = 0; k < lgi_pkg::NFAC; k++) begin
        jj     = (k < i) ? 2'(k) : 2'(k + 1);
        used_f = used_t && ({1'b0, jj} < point_count);
        nf_nxt[i][k] = used_f ? dt_m[jj] : DW'(1);
        df_nxt[i][k] = used_f ? dx_m[i][jj] : DW'(1);
        neg_nxt[i]   = neg_nxt[i] ^ (used_f & (dt_s[jj][DW] ^ dx_s[i][jj][DW]));
      end
    end
    ctrl_nxt.vld = in_valid;
    if (bad_cnt) begin
      ctrl_nxt.status = lgi_pkg::ST_BAD_COUNT;
    end else if (coinc) begin
      ctrl_nxt.status = lgi_pkg::ST_COINCIDENT;
    end else begin
      ctrl_nxt.status = lgi_pkg::ST_OK;
    end
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      ay_r  <= ay_nxt;
      nf_r  <= nf_nxt;
      df_r  <= df_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign ay_o   = ay_r;
  assign nf_o   = nf_r;
  assign df_o   = df_r;
  assign neg_o  = neg_r;
  assign ctrl_o = ctrl_r;

endmodule

`default_nettype wire

// ----- rtl/core/lgi_mul.sv -----
// Product stages: numerator and denominator magnitudes of each term,
// built from DW x DW multipliers over four register stages. Depends on lgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgi_mul #(
  parameter int unsigned DW = lgi_pkg::DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [DW-1:0]        ay_i  [lgi_pkg::NPTS],
  input  logic [DW-1:0]        nf_i  [lgi_pkg::NPTS][lgi_pkg::NFAC],
  input  logic [DW-1:0]        df_i  [lgi_pkg::NPTS][lgi_pkg::NFAC],
  input  logic [lgi_pkg::NPTS-1:0] neg_i,
  input  lgi_pkg::ctrl_t       ctrl_i,
  output logic [4*DW+1:0]      nn_o  [lgi_pkg::NPTS],
  output logic [3*DW:0]        dd_o  [lgi_pkg::NPTS],
  output logic [lgi_pkg::NPTS-1:0] neg_o,
  output lgi_pkg::ctrl_t       ctrl_o
);

  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned NUMW = 4 * DW;
  localparam int unsigned DENW = 3 * DW;
  localparam int unsigned NW   = NUMW + 2;
  localparam int unsigned DDW  = DENW + 1;
  localparam int unsigned NSTG = 4;

  // Stage A: first products
  logic [PW-1:0] p1_nxt [lgi_pkg::NPTS], q1_nxt [lgi_pkg::NPTS], r1_nxt [lgi_pkg::NPTS];
  logic [PW-1:0] p1_r   [lgi_pkg::NPTS], q1_r   [lgi_pkg::NPTS], r1_r   [lgi_pkg::NPTS];
  logic [DW-1:0] dc_r   [lgi_pkg::NPTS];
  // Stage B: partial products
  logic [PW-1:0] pll_nxt [lgi_pkg::NPTS], plh_nxt [lgi_pkg::NPTS];
  logic [PW-1:0] phl_nxt [lgi_pkg::NPTS], phh_nxt [lgi_pkg::NPTS];
  logic [PW-1:0] dlo_nxt [lgi_pkg::NPTS], dhi_nxt [lgi_pkg::NPTS];
  logic [PW-1:0] pll_r [lgi_pkg::NPTS], plh_r [lgi_pkg::NPTS];
  logic [PW-1:0] phl_r [lgi_pkg::NPTS], phh_r [lgi_pkg::NPTS];
  logic [PW-1:0] dlo_r [lgi_pkg::NPTS], dhi_r [lgi_pkg::NPTS];
  // Stage C: full magnitudes
  logic [NUMW-1:0] num_nxt [lgi_pkg::NPTS], num_r [lgi_pkg::NPTS];
  logic [DENW-1:0] den_nxt [lgi_pkg::NPTS], den_r [lgi_pkg::NPTS];
  // Stage D: rounding dividend and doubled divisor
  logic [NW-1:0]  nn_nxt [lgi_pkg::NPTS], nn_r [lgi_pkg::NPTS];
  logic [DDW-1:0] dd_nxt [lgi_pkg::NPTS], dd_r [lgi_pkg::NPTS];

  // Sideband delay line, one entry per stage
  logic [lgi_pkg::NPTS-1:0] neg_r  [NSTG];
  lgi_pkg::ctrl_t           ctrl_r [NSTG];

  // Multiply pairs of factors, then split into DW-wide partial products
  always_comb begin
    for (int l = 0; l < lgi_pkg::NPTS; l++) begin
      p1_nxt[l]  = ay_i[l] * nf_i[l][0];
      q1_nxt[l]  = nf_i[l][1] * nf_i[l][2];
      r1_nxt[l]  = df_i[l][0] * df_i[l][1];
      pll_nxt[l] = p1_r[l][DW-1:0]  * q1_r[l][DW-1:0];
      plh_nxt[l] = p1_r[l][DW-1:0]  * q1_r[l][PW-1:DW];
      phl_nxt[l] = p1_r[l][PW-1:DW] * q1_r[l][DW-1:0];
      phh_nxt[l] = p1_r[l][PW-1:DW] * q1_r[l][PW-1:DW];
      dlo_nxt[l] = r1_r[l][DW-1:0]  * dc_r[l];
      dhi_nxt[l] = r1_r[l][PW-1:DW] * dc_r[l];
      num_nxt[l] = NUMW'(pll_r[l]) + (NUMW'(plh_r[l]) << DW) +
                   (NUMW'(phl_r[l]) << DW) + (NUMW'(phh_r[l]) << (2 * DW));
      den_nxt[l] = DENW'(dlo_r[l]) + (DENW'(dhi_r[l]) << DW);
      // round to nearest: floor((2a + b) / 2b)
      nn_nxt[l]  = {1'b0, num_r[l], 1'b0} + NW'(den_r[l]);
      dd_nxt[l]  = {den_r[l], 1'b0};
    end
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        ctrl_r[s] <= '0;
      end
    end else if (en) begin
      ctrl_r[0] <= ctrl_i;
      for (int s = 1; s < NSTG; s++) begin
        ctrl_r[s] <= ctrl_r[s-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= neg_i;
      for (int s = 1; s < NSTG; s++) begin
        neg_r[s] <= neg_r[s-1];
      end
      for (int l = 0; l < lgi_pkg::NPTS; l++) begin
        p1_r[l]  <= p1_nxt[l];
        q1_r[l]  <= q1_nxt[l];
        r1_r[l]  <= r1_nxt[l];
        dc_r[l]  <= df_i[l][2];
        pll_r[l] <= pll_nxt[l];
        plh_r[l] <= plh_nxt[l];
        phl_r[l] <= phl_nxt[l];
        phh_r[l] <= phh_nxt[l];
        dlo_r[l] <= dlo_nxt[l];
        dhi_r[l] <= dhi_nxt[l];
        num_r[l] <= num_nxt[l];
        den_r[l] <= den_nxt[l];
        nn_r[l]  <= nn_nxt[l];
        dd_r[l]  <= dd_nxt[l];
      end
    end
  end

  assign nn_o   = nn_r;
  assign dd_o   = dd_r;
  assign neg_o  = neg_r[NSTG-1];
  assign ctrl_o = ctrl_r[NSTG-1];

endmodule

`default_nettype wire

// ----- rtl/core/lgi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// Carries sign and control alongside. Depends on lgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgi_div #(
  parameter int unsigned DW = lgi_pkg::DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [4*DW+1:0]      nn_i  [lgi_pkg::NPTS],
  input  logic [3*DW:0]        dd_i  [lgi_pkg::NPTS],
  input  logic [lgi_pkg::NPTS-1:0] neg_i,
  input  lgi_pkg::ctrl_t       ctrl_i,
  output logic [4*DW+1:0]      q_o   [lgi_pkg::NPTS],
  output logic [lgi_pkg::NPTS-1:0] neg_o,
  output lgi_pkg::ctrl_t       ctrl_o
);

  localparam int unsigned NW  = 4 * DW + 2;
  localparam int unsigned DDW = 3 * DW + 1;

  // Per stage: dividend bits shifting out, quotient bits shifting in
  logic [NW-1:0]  n_r   [NW][lgi_pkg::NPTS];
  logic [DDW-1:0] rem_r [NW][lgi_pkg::NPTS];
  logic [DDW-1:0] den_r [NW][lgi_pkg::NPTS];
  logic [lgi_pkg::NPTS-1:0] neg_r  [NW];
  lgi_pkg::ctrl_t           ctrl_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0]  n_in   [lgi_pkg::NPTS];
    logic [DDW-1:0] rem_in [lgi_pkg::NPTS];
    logic [DDW-1:0] den_in [lgi_pkg::NPTS];
    logic [lgi_pkg::NPTS-1:0] neg_in;
    lgi_pkg::ctrl_t           ctrl_in;
    logic [NW-1:0]  n_nxt   [lgi_pkg::NPTS];
    logic [DDW-1:0] rem_nxt [lgi_pkg::NPTS];

    if (s == 0) begin : g_first
      assign n_in    = nn_i;
      assign den_in  = dd_i;
      assign neg_in  = neg_i;
      assign ctrl_in = ctrl_i;
      for (genvar l = 0; l < lgi_pkg::NPTS; l++) begin : g_zero
        assign rem_in[l] = '0;
      end
    end else begin : g_next
      assign n_in    = n_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign neg_in  = neg_r[s-1];
      assign ctrl_in = ctrl_r[s-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
      logic [DDW:0] rs;
      logic         qb;
      rs = '0;
      qb = 1'b0;
      for (int l = 0; l < lgi_pkg::NPTS; l++) begin
        rs         = {rem_in[l], n_in[l][NW-1]};
        qb         = rs >= {1'b0, den_in[l]};
        rem_nxt[l] = qb ? DDW'(rs - {1'b0, den_in[l]}) : rs[DDW-1:0];
        n_nxt[l]   = {n_in[l][NW-2:0], qb};
      end
    end

    // Advance control
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctrl_r[s] <= '0;
      end else if (en) begin
        ctrl_r[s] <= ctrl_in;
      end
    end

    // Advance payload
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]   <= n_nxt;
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        neg_r[s] <= neg_in;
      end
    end
  end

  assign q_o    = n_r[NW-1];
  assign neg_o  = neg_r[NW-1];
  assign ctrl_o = ctrl_r[NW-1];

endmodule

`default_nettype wire

// ----- rtl/core/lgi_sum.sv -----
// Sum stages: apply term signs, add the four terms, saturate and hold the
// result in the output register. Depends on lgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgi_sum #(
  parameter int unsigned DW = lgi_pkg::DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [4*DW+1:0]      q_i   [lgi_pkg::NPTS],
  input  logic [lgi_pkg::NPTS-1:0] neg_i,
  input  lgi_pkg::ctrl_t       ctrl_i,
  output logic                 valid_o,
  output logic [DW-1:0]        value_o,
  output lgi_pkg::status_t     status_o
);

  localparam int unsigned NUMW = 4 * DW;
  localparam int unsigned SW   = NUMW + 3;
  localparam int unsigned NSTG = 3;
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW - 1){1'b0}}};

  logic [SW-1:0] t_nxt [lgi_pkg::NPTS], t_r [lgi_pkg::NPTS];
  logic [SW-1:0] s01_r, s23_r, acc_r;
  logic [DW-1:0] value_nxt, value_r;
  lgi_pkg::status_t status_nxt, status_r;
  lgi_pkg::ctrl_t   ctrl_r [NSTG];
  logic             valid_r;
  logic             fits;

  // Give each rounded quotient its sign
  always_comb begin
    for (int l = 0; l < lgi_pkg::NPTS; l++) begin
      t_nxt[l] = neg_i[l] ? (~SW'(q_i[l][NUMW-1:0]) + 1'b1) : SW'(q_i[l][NUMW-1:0]);
    end
  end

  // Saturate the sum; an input error forces zero
  always_comb begin
    fits = (&acc_r[SW-1:DW-1]) || !(|acc_r[SW-1:DW-1]);
    if (ctrl_r[NSTG-1].status != lgi_pkg::ST_OK) begin
      value_nxt  = '0;
      status_nxt = ctrl_r[NSTG-1].status;
    end else if (!fits) begin
      value_nxt  = acc_r[SW-1] ? VMIN : VMAX;
      status_nxt = lgi_pkg::ST_SATURATED;
    end else begin
      value_nxt  = acc_r[DW-1:0];
      status_nxt = lgi_pkg::ST_OK;
    end
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        ctrl_r[s] <= '0;
      end
      valid_r <= 1'b0;
    end else if (en) begin
      ctrl_r[0] <= ctrl_i;
      for (int s = 1; s < NSTG; s++) begin
        ctrl_r[s] <= ctrl_r[s-1];
      end
      valid_r <= ctrl_r[NSTG-1].vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      t_r      <= t_nxt;
      s01_r    <= t_r[0] + t_r[1];
      s23_r    <= t_r[2] + t_r[3];
      acc_r    <= s01_r + s23_r;
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign value_o  = value_r;
  assign status_o = status_r;

endmodule

`default_nettype wire

// ----- rtl/core/lagrange_interpolator.sv -----
// Lagrange interpolator, linear to cubic, signed fixed point.
// Top level; instantiates lgi_front, lgi_mul, lgi_div and lgi_sum, uses lgi_pkg.
//
// Usage:
//   Input channel (in_valid / in_ready) carries the target abscissa, four
//   sample points and the point count (2, 3 or 4). The result channel
//   (out_valid / out_ready) returns the interpolated value and a status:
//   ok, bad point count, coincident abscissae (both with value 0) or
//   saturated (value clamped to the largest or smallest code).
//   Each term is formed exactly and rounded to nearest, ties away from zero.
//
//   Throughput: one item per cycle while the result channel is not stalled.
//   The divider makes up most of the pipeline depth; it resolves one quotient
//   bit per stage over 4*DATA_WIDTH+2 stages, four lanes side by side.
//   The pipeline is one stall domain: while out_valid is high and out_ready
//   low, every stage holds and in_ready is low; nothing is dropped or repeated.
//   Reset empties the pipeline (all valid bits cleared); there is no other
//   state and no configuration.
`timescale 1ns / 1ps
`default_nettype none

module lagrange_interpolator #(
  parameter int unsigned DATA_WIDTH = lgi_pkg::DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_target_x,
  input  logic signed [DATA_WIDTH-1:0] in_x0,
  input  logic signed [DATA_WIDTH-1:0] in_x1,
  input  logic signed [DATA_WIDTH-1:0] in_x2,
  input  logic signed [DATA_WIDTH-1:0] in_x3,
  input  logic signed [DATA_WIDTH-1:0] in_y0,
  input  logic signed [DATA_WIDTH-1:0] in_y1,
  input  logic signed [DATA_WIDTH-1:0] in_y2,
  input  logic signed [DATA_WIDTH-1:0] in_y3,
  input  logic [2:0]                   in_point_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic [1:0]                   out_status
);

  localparam int unsigned DW = DATA_WIDTH;

  logic en;
  logic [DW-1:0] xs [lgi_pkg::NPTS];
  logic [DW-1:0] ys [lgi_pkg::NPTS];

  logic [DW-1:0] ay [lgi_pkg::NPTS];
  logic [DW-1:0] nf [lgi_pkg::NPTS][lgi_pkg::NFAC];
  logic [DW-1:0] df [lgi_pkg::NPTS][lgi_pkg::NFAC];
  logic [lgi_pkg::NPTS-1:0] neg_f, neg_m, neg_d;
  lgi_pkg::ctrl_t ctrl_f, ctrl_m, ctrl_d;

  logic [4*DW+1:0] nn [lgi_pkg::NPTS];
  logic [3*DW:0]   dd [lgi_pkg::NPTS];
  logic [4*DW+1:0] qq [lgi_pkg::NPTS];

  logic [DW-1:0]    value;
  lgi_pkg::status_t status;

  // Hold every stage while a result waits on the receiver
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  assign xs[0] = in_x0;
  assign xs[1] = in_x1;
  assign xs[2] = in_x2;
  assign xs[3] = in_x3;
  assign ys[0] = in_y0;
  assign ys[1] = in_y1;
  assign ys[2] = in_y2;
  assign ys[3] = in_y3;

  lgi_front #(.DW(DW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .target_x    (in_target_x),
    .x_i         (xs),
    .y_i         (ys),
    .point_count (in_point_count),
    .ay_o        (ay),
    .nf_o        (nf),
    .df_o        (df),
    .neg_o       (neg_f),
    .ctrl_o      (ctrl_f)
  );

  lgi_mul #(.DW(DW)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ay_i   (ay),
    .nf_i   (nf),
    .df_i   (df),
    .neg_i  (neg_f),
    .ctrl_i (ctrl_f),
    .nn_o   (nn),
    .dd_o   (dd),
    .neg_o  (neg_m),
    .ctrl_o (ctrl_m)
  );

  lgi_div #(.DW(DW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .nn_i   (nn),
    .dd_i   (dd),
    .neg_i  (neg_m),
    .ctrl_i (ctrl_m),
    .q_o    (qq),
    .neg_o  (neg_d),
    .ctrl_o (ctrl_d)
  );

  lgi_sum #(.DW(DW)) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .q_i      (qq),
    .neg_i    (neg_d),
    .ctrl_i   (ctrl_d),
    .valid_o  (out_valid),
    .value_o  (value),
    .status_o (status)
  );

  assign out_value  = value;
  assign out_status = status;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking bench for lagrange_interpolator: directed and random items.
// Holds its own exact-integer interpolation predictor; depends on lgi_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int W = 32;
  localparam int RAND_ITEMS = 1630;
  localparam int CYCLE_LIMIT = 2000000;

  typedef logic signed [263:0] wint_t;
  typedef logic [263:0] wmag_t;

  typedef struct {
    logic signed [W-1:0] tx;
    logic signed [W-1:0] xs [4];
    logic signed [W-1:0] ys [4];
    logic [2:0] cnt;
  } sample_set_t;

  typedef struct {
    logic signed [W-1:0] value;
    lgi_pkg::status_t status;
  } interp_res_t;

  // Predict interpolations and match them against the result stream
  class interp_scoreboard;
    interp_res_t pending [$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function interp_res_t evaluate(sample_set_t s);
      interp_res_t r;
      wint_t acc, num, den, term;
      wmag_t a, b, q;
      bit neg;
      int n;
      r.value = '0;
      r.status = lgi_pkg::ST_OK;
      n = s.cnt;
      if (n < 2 || n > 4) begin
        r.status = lgi_pkg::ST_BAD_COUNT;
        return r;
      end
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++)
          if (s.xs[i] == s.xs[j]) begin
            r.status = lgi_pkg::ST_COINCIDENT;
            return r;
          end
      acc = '0;
      // form each term exactly, round half away from zero on magnitudes
      for (int i = 0; i < n; i++) begin
        num = s.ys[i];
        den = 1;
        for (int j = 0; j < n; j++) begin
          if (j == i) continue;
          num = num * (wint_t'(s.tx) - wint_t'(s.xs[j]));
          den = den * (wint_t'(s.xs[i]) - wint_t'(s.xs[j]));
        end
        neg = num[263] ^ den[263];
        a = num[263] ? -num : num;
        b = den[263] ? -den : den;
        q = (2 * a + b) / (2 * b);
        term = neg ? -wint_t'(q) : wint_t'(q);
        acc = acc + term;
      end
      // clamp to the value width
      if (acc > wint_t'(2147483647)) begin
        r.value = 32'sh7fffffff;
        r.status = lgi_pkg::ST_SATURATED;
      end else if (acc < -wint_t'(64'sd2147483648)) begin
        r.value = 32'sh80000000;
        r.status = lgi_pkg::ST_SATURATED;
      end else begin
        r.value = acc[W-1:0];
      end
      return r;
    endfunction

    function void note_item(sample_set_t s);
      pending.push_back(evaluate(s));
    endfunction

    task check_result(logic signed [W-1:0] value, logic [1:0] status);
      interp_res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%0d status=%0d", value, status));
        return;
      end
      e = pending.pop_front();
      if (value !== e.value)
        report($sformatf("value got %0d exp %0d", value, e.value));
      if (status !== e.status)
        report($sformatf("status got %0d exp %0d", status, e.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] in_target_x = '0;
  logic signed [W-1:0] in_x0 = '0, in_x1 = '0, in_x2 = '0, in_x3 = '0;
  logic signed [W-1:0] in_y0 = '0, in_y1 = '0, in_y2 = '0, in_y3 = '0;
  logic [2:0] in_point_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] out_value;
  logic [1:0] out_status;

  interp_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  lagrange_interpolator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_x(in_target_x),
    .in_x0(in_x0), .in_x1(in_x1), .in_x2(in_x2), .in_x3(in_x3),
    .in_y0(in_y0), .in_y1(in_y1), .in_y2(in_y2), .in_y3(in_y3),
    .in_point_count(in_point_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  always #10 clk = ~clk;

  // Stall the result side at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Observe both handshakes
  always @(posedge clk) begin
    sample_set_t s;
    if (rst_n && in_valid && in_ready) begin
      s.tx = in_target_x;
      s.xs[0] = in_x0; s.xs[1] = in_x1; s.xs[2] = in_x2; s.xs[3] = in_x3;
      s.ys[0] = in_y0; s.ys[1] = in_y1; s.ys[2] = in_y2; s.ys[3] = in_y3;
      s.cnt = in_point_count;
      sb.note_item(s);
    end
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_value, out_status);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one item, after a random idle gap, and hold it until taken
  task send(sample_set_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_x <= s.tx;
    in_x0 <= s.xs[0]; in_x1 <= s.xs[1]; in_x2 <= s.xs[2]; in_x3 <= s.xs[3];
    in_y0 <= s.ys[0]; in_y1 <= s.ys[1]; in_y2 <= s.ys[2]; in_y3 <= s.ys[3];
    in_point_count <= s.cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [W-1:0] rand_val();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $signed(32'($urandom_range(2097152))) - 32'sd1048576;
    if (sel < 8) return $signed(32'($urandom_range(67108864))) - 32'sd33554432;
    return $signed($urandom);
  endfunction

  function automatic sample_set_t make_set(logic signed [W-1:0] tx,
      logic signed [W-1:0] a0, logic signed [W-1:0] a1, logic signed [W-1:0] a2,
      logic signed [W-1:0] a3, logic signed [W-1:0] b0, logic signed [W-1:0] b1,
      logic signed [W-1:0] b2, logic signed [W-1:0] b3, logic [2:0] cnt);
    sample_set_t s;
    s.tx = tx;
    s.xs[0] = a0; s.xs[1] = a1; s.xs[2] = a2; s.xs[3] = a3;
    s.ys[0] = b0; s.ys[1] = b1; s.ys[2] = b2; s.ys[3] = b3;
    s.cnt = cnt;
    return s;
  endfunction

  // Random item: mostly well-formed, some bad counts, coincident abscissae and targets on a sample
  function automatic sample_set_t rand_set();
    sample_set_t s;
    int sel, n, i, j;
    s.tx = rand_val();
    for (i = 0; i < 4; i++) begin
      s.xs[i] = rand_val();
      s.ys[i] = rand_val();
    end
    sel = $urandom_range(99);
    if (sel < 10) begin
      s.cnt = 3'($urandom_range(7));
    end else begin
      s.cnt = 3'($urandom_range(4, 2));
      n = s.cnt;
      if (sel < 18) begin
        i = $urandom_range(n - 1);
        j = $urandom_range(n - 1);
        if (i == j) j = (i + 1) % n;
        s.xs[j] = s.xs[i];
      end else if (sel < 28) begin
        s.tx = s.xs[$urandom_range(n - 1)];
      end
    end
    return s;
  endfunction

  localparam logic signed [W-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] VMIN = 32'sh80000000;
  localparam logic signed [W-1:0] ONE = 32'sh00010000;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: counts, coincidences, samples hit, extremes, saturation
    send(make_set(ONE, 0, 2*ONE, 0, 0, 0, 4*ONE, 0, 0, 3'd2));
    send(make_set(ONE, 0, ONE, 2*ONE, 0, 0, ONE, 4*ONE, 0, 3'd3));
    send(make_set(5*ONE, 0, ONE, 2*ONE, 3*ONE, 0, ONE, 8*ONE, 27*ONE, 3'd4));
    for (int c = 0; c < 8; c++)
      if (c < 2 || c > 4) send(make_set(ONE, 0, ONE, 2*ONE, 3*ONE, 1, 2, 3, 4, 3'(c)));
    send(make_set(ONE, 7, 7, 2*ONE, 3*ONE, 1, 2, 3, 4, 3'd2));
    send(make_set(ONE, 0, ONE, 0, 3*ONE, 1, 2, 3, 4, 3'd4));
    send(make_set(ONE, 0, ONE, 2*ONE, ONE, 1, 2, 3, 4, 3'd3));
    send(make_set(ONE, 0, ONE, 0, 0, 1, 2, 3, 4, 3'd2));
    send(make_set(2*ONE, 0, ONE, 2*ONE, 3*ONE, 11, 22, -33, 44, 3'd4));
    send(make_set(VMAX, VMIN, VMAX, 0, 0, VMIN, VMAX, 0, 0, 3'd2));
    send(make_set(VMIN, VMIN, VMAX, 0, 0, VMIN, VMAX, 0, 0, 3'd2));
    send(make_set(VMAX, 0, 1, 2, 3, VMAX, VMIN, VMAX, VMIN, 3'd4));
    send(make_set(VMIN, 0, 1, 2, 3, VMIN, VMAX, VMIN, VMAX, 3'd4));
    send(make_set(VMAX, VMIN, -1, 0, 1, VMAX, VMAX, VMIN, VMIN, 3'd4));
    send(make_set(3, 0, 2, 0, 0, 0, 1, 0, 0, 3'd2));
    send(make_set(1, 0, 2, 0, 0, 0, -1, 0, 0, 3'd2));
    send(make_set(ONE, 0, 3, 5, 0, VMAX, -1, VMIN, 0, 3'd3));

    // random: four phases of input idling and result stalling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 63 : 0;
      stall_pct = (ph == 2) ? 63 : (ph == 3) ? 16 : 0;
      if (ph == 3) idle_pct = 16;
      for (int k = 0; k < RAND_ITEMS / 4; k++) send(rand_set());
    end
    in_valid <= 1'b0;

    // drain, then allow the pipeline latency to expose strays
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
